>>> rtl/rcast_pkg.sv
`timescale 1ns / 1ps
package rcast_pkg;
  localparam int unsigned CountWidth = 11;
  localparam int unsigned ValueWidth = 40;
  localparam int unsigned SumWidth   = 64;
  localparam int unsigned TypeWidth  = 3;

  typedef enum logic [2:0] {
    REQ_CHMIN = 3'd0,
    REQ_CHMAX = 3'd1,
    REQ_ADD   = 3'd2,
    REQ_SUM   = 3'd3,
    REQ_LOAD  = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_e;
endpackage

>>> rtl/range_clamp_add_sum_table.sv
`timescale 1ns / 1ps
// range clamp / add / sum over a table of signed 64-bit elements held in one
// single-port synchronous ram; after reset the block sweeps the ram to zero,
// one entry a cycle, while no request is taken; a request then walks its
// clipped range one element at a time: each element takes a read state, then
// a modify state that writes chmin, chmax and add results back, and a last
// read state that finds the range end is followed by a done state; the input
// stalls until the block is back in idle, so a new request is not taken
// before the last one is through; loads, unknown types and empty ranges go
// from read straight to done; a sum result is held in an output register
// until taken while the next request is already accepted; a later sum holds
// in its done cycle until the earlier one has gone
module range_clamp_add_sum_table #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcast_pkg::CountWidth-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rcast_pkg::TypeWidth-1:0]     req_type_i,
  input  logic [rcast_pkg::CountWidth-1:0]    range_lo_i,
  input  logic [rcast_pkg::CountWidth-1:0]    range_hi_i,
  input  logic signed [rcast_pkg::ValueWidth-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rcast_pkg::SumWidth-1:0] range_sum_o
);
  localparam int unsigned AddrWidth = $clog2(MAX_ELEMENTS);
  localparam int unsigned IdxWidth  = AddrWidth + 1;
  localparam logic [IdxWidth-1:0] MaxIdx = IdxWidth'(MAX_ELEMENTS);

  logic [rcast_pkg::CountWidth-1:0] count_q;
  rcast_pkg::state_e state_q, state_d;
  logic [2:0]          type_q;
  logic [IdxWidth-1:0] idx_q, idx_d, hi_q;
  logic [63:0]         x_q, acc_q;
  logic                out_valid_q;
  logic [63:0]         sum_q;
  logic                ld_ok_q;

  logic [63:0] mem [MAX_ELEMENTS];
  logic [63:0] rdata_q, wdata;
  logic        we;
  logic        accept;
  logic        done_go;

  // clip counts to the table size
  logic [IdxWidth-1:0] used, lo_c, hi_c;
  always_comb begin
    logic [IdxWidth+10:0] cnt;
    cnt  = (IdxWidth+11)'(count_q);
    used = (cnt > (IdxWidth+11)'(MAX_ELEMENTS)) ? MaxIdx : IdxWidth'(cnt);
    lo_c = ((IdxWidth+11)'(range_lo_i) > (IdxWidth+11)'(used)) ? used
                                                              : IdxWidth'(range_lo_i);
    hi_c = ((IdxWidth+11)'(range_hi_i) > (IdxWidth+11)'(used)) ? used
                                                              : IdxWidth'(range_hi_i);
  end

  // a request is taken only in idle
  assign in_stall_o = (state_q != rcast_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // a finished sum may leave done only once the output register is free
  assign done_go = !((type_q == rcast_pkg::REQ_SUM) && out_valid_q && out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcast_pkg::ST_CLEAR:  if (idx_q == MaxIdx - 1'b1) state_d = rcast_pkg::ST_IDLE;
      rcast_pkg::ST_IDLE:   if (accept) state_d = rcast_pkg::ST_READ;
      rcast_pkg::ST_READ:   state_d = (idx_q < hi_q) ? rcast_pkg::ST_MODIFY
                                                    : rcast_pkg::ST_DONE;
      rcast_pkg::ST_MODIFY: state_d = rcast_pkg::ST_READ;
      rcast_pkg::ST_DONE:   if (done_go) state_d = rcast_pkg::ST_IDLE;
      default:              state_d = rcast_pkg::ST_IDLE;
    endcase
  end

  // element update and write strobe
  always_comb begin
    we    = 1'b0;
    wdata = rdata_q;
    idx_d = idx_q;
    unique case (state_q)
      rcast_pkg::ST_CLEAR: begin
        we = 1'b1; wdata = '0; idx_d = idx_q + 1'b1;
      end
      rcast_pkg::ST_MODIFY: begin
        idx_d = idx_q + 1'b1;
        unique case (type_q)
          rcast_pkg::REQ_CHMIN: begin
            we = 1'b1;
            if ($signed(x_q) < $signed(rdata_q)) wdata = x_q;
          end
          rcast_pkg::REQ_CHMAX: begin
            we = 1'b1;
            if ($signed(rdata_q) < $signed(x_q)) wdata = x_q;
          end
          rcast_pkg::REQ_ADD: begin
            we = 1'b1; wdata = rdata_q + x_q;
          end
          default: we = 1'b0;
        endcase
      end
      // a load in range writes its element in the done cycle
      rcast_pkg::ST_DONE: begin
        if (type_q == rcast_pkg::REQ_LOAD && ld_ok_q) begin
          we = 1'b1; wdata = x_q;
        end
      end
      default: ;
    endcase
  end

  // read issued in read state, data back for modify
  always_ff @(posedge clk_i) begin
    if (we) mem[idx_q[AddrWidth-1:0]] <= wdata;
    rdata_q <= mem[idx_q[AddrWidth-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcast_pkg::ST_CLEAR;
      idx_q       <= '0;
      count_q     <= rcast_pkg::CountWidth'(1024);
      out_valid_q <= 1'b0;
      type_q      <= '0;
      hi_q        <= '0;
      ld_ok_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (state_q == rcast_pkg::ST_DONE && type_q == rcast_pkg::REQ_SUM && done_go)
        out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i)
        out_valid_q <= 1'b0;
      if (accept) begin
        type_q  <= req_type_i;
        ld_ok_q <= (req_type_i == rcast_pkg::REQ_LOAD)
                   && ((IdxWidth+11)'(range_lo_i) < (IdxWidth+11)'(used));
        if (req_type_i == rcast_pkg::REQ_LOAD) begin
          idx_q <= IdxWidth'(range_lo_i[AddrWidth-1:0]);
          hi_q  <= '0;
        end else if (req_type_i > rcast_pkg::REQ_LOAD) begin
          idx_q <= '0;
          hi_q  <= '0;
        end else begin
          idx_q <= lo_c;
          hi_q  <= hi_c;
        end
      end else if (state_q == rcast_pkg::ST_CLEAR) begin
        idx_q <= (state_d == rcast_pkg::ST_IDLE) ? '0 : idx_d;
      end else begin
        idx_q <= idx_d;
      end
    end
  end

  // sum accumulation and operand capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= {{24{value_i[39]}}, value_i};
      acc_q <= '0;
    end
    if (state_q == rcast_pkg::ST_MODIFY && type_q == rcast_pkg::REQ_SUM)
      acc_q <= acc_q + rdata_q;
    if (state_q == rcast_pkg::ST_DONE && type_q == rcast_pkg::REQ_SUM && done_go)
      sum_q <= acc_q;
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = sum_q;

`ifndef NO_ASSERTIONS
  a_no_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcast_pkg::ST_CLEAR) |-> !out_valid_q) else $error("result during clear");
  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rcast_pkg::ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcast_pkg::ST_MODIFY) |-> (idx_q < hi_q)) else $error("index beyond range");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(sum_q)))
    else $error("stalled result changed");
`endif
endmodule
